// ===== rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is held.
`define SSC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define SSC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/ssc_pkg.sv =====
// ----------------------------------------------------------------------------
// ssc_pkg: sphere contact types
// Item layouts and side-band data carried down the contact pipeline.
// ----------------------------------------------------------------------------
package ssc_pkg;

  localparam int IdW    = 10;
  localparam int CoordW = 32;
  localparam int RadW   = 31;

  typedef struct packed {
    logic [IdW-1:0]           first_id;
    logic [IdW-1:0]           second_id;
    logic signed [CoordW-1:0] a_x;
    logic signed [CoordW-1:0] a_y;
    logic signed [CoordW-1:0] a_z;
    logic [RadW-1:0]          a_radius;
    logic signed [CoordW-1:0] b_x;
    logic signed [CoordW-1:0] b_y;
    logic signed [CoordW-1:0] b_z;
    logic [RadW-1:0]          b_radius;
  } in_item_t;

  typedef struct packed {
    logic [IdW-1:0]           owner_id;
    logic [IdW-1:0]           partner_id;
    logic signed [CoordW-1:0] point_x;
    logic signed [CoordW-1:0] point_y;
    logic signed [CoordW-1:0] point_z;
    logic signed [CoordW-1:0] normal_x;
    logic signed [CoordW-1:0] normal_y;
    logic signed [CoordW-1:0] normal_z;
    logic [CoordW-1:0]        overlap;
    logic                     last_record;
  } out_item_t;

  // Data that rides along with an item through the pipeline.
  typedef struct packed {
    logic [IdW-1:0]               first_id;
    logic [IdW-1:0]               second_id;
    logic [2:0][CoordW-1:0]       pnt;
    logic [2:0]                   neg;
    logic [CoordW-1:0]            rsum;
    logic [2:0][CoordW-1:0]       mag;
    logic                         hit;
  } ssc_side_t;

endpackage

// ===== rtl/sphere_sphere_contact.sv =====
// Each hit leaves as its record of a, then its record of b.
// A pair enters every cycle unless a hit holds the pipeline until its record of b is
// loaded (two records leave through a single output register); a miss never holds it.
// Most of the pipeline is the 32-step square root pipeline and the 31-step divider.
// Synchronous active-low reset clears all valid bits and the record phase.
// ----------------------------------------------------------------------------
// sphere_sphere_contact: pipelined sphere pair contact test
// Center distance by pipelined integer square root, normal by pipelined
// restoring division, two contact records per hit.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sphere_sphere_contact (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  ssc_pkg::in_item_t in_item,
  output logic              out_valid,
  input  logic              out_stall,
  output ssc_pkg::out_item_t out_item
);

  localparam int SqN = 32;   // root bits
  localparam int DvN = 31;   // quotient bits (normal magnitude up to 2^30)

  // Whole pipeline moves together.
  logic adv;

  // --------------------------------------------------------------------------
  // Stage 1: center difference, center sum, radius sum
  // --------------------------------------------------------------------------
  logic                     v1_r;
  logic signed [32:0]       d1_r [3];
  logic [31:0]              p1_r [3];
  logic [31:0]              rs1_r;
  logic [ssc_pkg::IdW-1:0]  ida1_r, idb1_r;

  logic signed [32:0] ain [3];
  logic signed [32:0] bin [3];
  logic signed [32:0] csum [3];

  always_comb begin
    ain[0] = 33'(in_item.a_x);
    ain[1] = 33'(in_item.a_y);
    ain[2] = 33'(in_item.a_z);
    bin[0] = 33'(in_item.b_x);
    bin[1] = 33'(in_item.b_y);
    bin[2] = 33'(in_item.b_z);
    for (int i = 0; i < 3; i++) begin
      csum[i] = ain[i] + bin[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        d1_r[i] <= bin[i] - ain[i];
        p1_r[i] <= csum[i][32:1];   // arithmetic halving, floor
      end
      rs1_r  <= 32'(in_item.a_radius) + 32'(in_item.b_radius);
      ida1_r <= in_item.first_id;
      idb1_r <= in_item.second_id;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: magnitudes and the per-axis reject
  // --------------------------------------------------------------------------
  logic               v2_r;
  ssc_pkg::ssc_side_t s2_r;
  ssc_pkg::ssc_side_t s2_nxt;
  logic [32:0]        mag33 [3];

  always_comb begin
    s2_nxt           = '0;
    s2_nxt.first_id  = ida1_r;
    s2_nxt.second_id = idb1_r;
    s2_nxt.rsum      = rs1_r;
    s2_nxt.hit       = 1'b1;
    for (int i = 0; i < 3; i++) begin
      mag33[i]       = d1_r[i][32] ? 33'(-d1_r[i]) : 33'(d1_r[i]);
      s2_nxt.pnt[i]  = p1_r[i];
      s2_nxt.neg[i]  = d1_r[i][32];
      s2_nxt.mag[i]  = mag33[i][31:0];
      if (mag33[i] >= {1'b0, rs1_r}) begin
        s2_nxt.hit = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (adv) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_r <= s2_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: squares and squared radius sum
  // --------------------------------------------------------------------------
  logic               v3_r;
  ssc_pkg::ssc_side_t s3_r;
  logic [63:0]        sq3_r [3];
  logic [63:0]        rr3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (adv) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_r <= s2_r;
      for (int i = 0; i < 3; i++) begin
        sq3_r[i] <= 64'(s2_r.mag[i]) * 64'(s2_r.mag[i]);
      end
      rr3_r <= 64'(s2_r.rsum) * 64'(s2_r.rsum);
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: squared distance
  // --------------------------------------------------------------------------
  logic               v4_r;
  ssc_pkg::ssc_side_t s4_r;
  logic [65:0]        sum4_r;
  logic [63:0]        rr4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (adv) begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_r   <= s3_r;
      sum4_r <= 66'(sq3_r[0]) + 66'(sq3_r[1]) + 66'(sq3_r[2]);
      rr4_r  <= rr3_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 5 (root step 0 input): distance reject
  // --------------------------------------------------------------------------
  logic               sq_v_r    [SqN+1];
  ssc_pkg::ssc_side_t sq_side_r [SqN+1];
  logic [63:0]        sq_rem_r  [SqN+1];
  logic [31:0]        sq_root_r [SqN+1];
  ssc_pkg::ssc_side_t sq_side_nxt;

  always_comb begin
    sq_side_nxt     = s4_r;
    // overflow past 64 bits is always at or above the squared radius sum
    sq_side_nxt.hit = s4_r.hit && (sum4_r < {2'b00, rr4_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_v_r[0] <= 1'b0;
    end else if (adv) begin
      sq_v_r[0] <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_side_r[0] <= sq_side_nxt;
      sq_rem_r[0]  <= sum4_r[63:0];
      sq_root_r[0] <= '0;
    end
  end

  // --------------------------------------------------------------------------
  // Integer square root, one root bit per stage, MSB first
  // --------------------------------------------------------------------------
  for (genvar k = 0; k < SqN; k++) begin : g_sq
    localparam int B = SqN - 1 - k;
    logic [65:0] trial;
    logic        take;

    // (root + 2^B)^2 - root^2
    assign trial = (66'(sq_root_r[k]) << (B + 1)) + (66'(1) << (2 * B));
    assign take  = {2'b00, sq_rem_r[k]} >= trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_v_r[k+1] <= 1'b0;
      end else if (adv) begin
        sq_v_r[k+1] <= sq_v_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        sq_side_r[k+1] <= sq_side_r[k];
        sq_rem_r[k+1]  <= take ? 64'({2'b00, sq_rem_r[k]} - trial) : sq_rem_r[k];
        sq_root_r[k+1] <= take ? (sq_root_r[k] | (32'(1) << B)) : sq_root_r[k];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Divider input stage: overlap, zero-distance flag, first partial remainders
  // --------------------------------------------------------------------------
  logic               dv_v_r    [DvN+1];
  ssc_pkg::ssc_side_t dv_side_r [DvN+1];
  logic [31:0]        dv_dist_r [DvN+1];
  logic [31:0]        dv_ov_r   [DvN+1];
  logic               dv_dz_r   [DvN+1];
  logic [2:0][32:0]   dv_rem_r  [DvN+1];
  logic [2:0][30:0]   dv_quo_r  [DvN+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_v_r[0] <= 1'b0;
    end else if (adv) begin
      dv_v_r[0] <= sq_v_r[SqN];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_side_r[0] <= sq_side_r[SqN];
      dv_dist_r[0] <= sq_root_r[SqN];
      dv_ov_r[0]   <= sq_side_r[SqN].rsum - sq_root_r[SqN];
      dv_dz_r[0]   <= (sq_root_r[SqN] == '0);
      for (int i = 0; i < 3; i++) begin
        // magnitude never exceeds the distance, so this start is below it
        dv_rem_r[0][i] <= {2'b00, sq_side_r[SqN].mag[i][31:1]};
      end
      dv_quo_r[0] <= '0;
    end
  end

  // --------------------------------------------------------------------------
  // Restoring division, three lanes, one quotient bit per stage
  // --------------------------------------------------------------------------
  for (genvar j = 0; j < DvN; j++) begin : g_dv
    logic [2:0][32:0] rs;
    logic [2:0][32:0] nrem;
    logic [2:0]       qb;

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        // dividend is mag << 30: its bit 0 enters first, then zeros
        rs[i]   = {dv_rem_r[j][i][31:0], (j == 0) ? dv_side_r[j].mag[i][0] : 1'b0};
        qb[i]   = rs[i] >= {1'b0, dv_dist_r[j]};
        nrem[i] = qb[i] ? (rs[i] - {1'b0, dv_dist_r[j]}) : rs[i];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_v_r[j+1] <= 1'b0;
      end else if (adv) begin
        dv_v_r[j+1] <= dv_v_r[j];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dv_side_r[j+1] <= dv_side_r[j];
        dv_dist_r[j+1] <= dv_dist_r[j];
        dv_ov_r[j+1]   <= dv_ov_r[j];
        dv_dz_r[j+1]   <= dv_dz_r[j];
        dv_rem_r[j+1]  <= nrem;
        for (int i = 0; i < 3; i++) begin
          dv_quo_r[j+1][i] <= {dv_quo_r[j][i][29:0], qb[i]};
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Record output: hit items leave as two records, misses are dropped
  // --------------------------------------------------------------------------
  logic               p_v;
  logic               p_hit;
  ssc_pkg::ssc_side_t p_side;
  logic [31:0]        nrm_a [3];
  logic [31:0]        nrm_b [3];
  ssc_pkg::out_item_t rec_a, rec_b;

  logic               out_valid_r, out_valid_nxt;
  ssc_pkg::out_item_t out_item_r, out_item_nxt;
  logic               phase_r, phase_nxt;   // record of a already sent
  logic               load;

  assign p_v    = dv_v_r[DvN];
  assign p_side = dv_side_r[DvN];
  assign p_hit  = p_side.hit;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      nrm_a[i] = dv_dz_r[DvN] ? '0 : {1'b0, dv_quo_r[DvN][i]};
      if (p_side.neg[i]) begin
        nrm_a[i] = -nrm_a[i];
      end
      nrm_b[i] = -nrm_a[i];
    end

    rec_a             = '0;
    rec_a.owner_id    = p_side.first_id;
    rec_a.partner_id  = p_side.second_id;
    rec_a.point_x     = p_side.pnt[0];
    rec_a.point_y     = p_side.pnt[1];
    rec_a.point_z     = p_side.pnt[2];
    rec_a.normal_x    = nrm_a[0];
    rec_a.normal_y    = nrm_a[1];
    rec_a.normal_z    = nrm_a[2];
    rec_a.overlap     = dv_ov_r[DvN];
    rec_a.last_record = 1'b0;

    rec_b             = rec_a;
    rec_b.owner_id    = p_side.second_id;
    rec_b.partner_id  = p_side.first_id;
    rec_b.normal_x    = nrm_b[0];
    rec_b.normal_y    = nrm_b[1];
    rec_b.normal_z    = nrm_b[2];
    rec_b.last_record = 1'b1;
  end

  assign load = !out_valid_r || !out_stall;
  // pipeline moves unless a hit still owes its record of b
  assign adv  = !p_v || !p_hit || (load && phase_r);

  always_comb begin
    out_item_nxt  = out_item_r;
    out_valid_nxt = out_valid_r;
    phase_nxt     = phase_r;
    if (load) begin
      out_valid_nxt = 1'b0;
      if (p_v && p_hit) begin
        out_item_nxt  = phase_r ? rec_b : rec_a;
        out_valid_nxt = 1'b1;
        phase_nxt     = !phase_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      phase_r     <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      phase_r     <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

  assign in_stall  = !adv;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `SSC_ASSERT(a_b_follows_a, (out_valid_r && !out_stall && !out_item_r.last_record) |=> (out_valid_r && out_item_r.last_record), "record of b did not follow record of a")
  `SSC_ASSERT(a_phase_has_item, phase_r |-> (p_v && p_hit), "record phase set without a held hit")
  `SSC_ASSERT(a_empty_no_stall, !p_v |-> !in_stall, "input stalled with empty pipeline tail")

endmodule
